@@ sv/pli_pkg.sv @@
// Shared types and constants of the positional list unit.
package pli_pkg;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ELEM_W = 32;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_DUMP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_ELEM  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } state_e;

  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_INSERT,
    SHIFT_DELETE,
    SHIFT_ROTATE
  } shift_e;

  typedef struct packed {
    logic    load;
    shift_e  shift;
    logic    emit;
    logic    emit_elem;
    status_e emit_status;
  } pli_cmd_t;

  typedef struct packed {
    func_e func;
    logic  pos_err;
    logic  full;
    logic  empty;
    logic  dump_last;
    logic  out_free;
  } pli_stat_t;

endpackage

@@ sv/pli_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
interface pli_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       func;
  logic [pli_pkg::POS_W-1:0]        position;
  logic signed [pli_pkg::VAL_W-1:0] value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

interface pli_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pli_pkg::ELEM_W-1:0] element;
  logic                              last;
  logic [1:0]                        status;

  modport source (output valid, element, last, status, input ready);
  modport sink   (input valid, element, last, status, output ready);
endinterface

@@ sv/pli_ctrl.sv @@
// Controller state machine of the positional list unit.
module pli_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pli_pkg::pli_stat_t stat_i,
  output pli_pkg::pli_cmd_t  cmd_o
);
  import pli_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.shift       = SHIFT_NONE;
    cmd_o.emit        = 1'b0;
    cmd_o.emit_elem   = 1'b0;
    cmd_o.emit_status = STAT_ELEM;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (stat_i.func) inside
          FUNC_APPEND, FUNC_INSERT: begin
            if (stat_i.pos_err || stat_i.full) begin
              // error beat waits for a free output register
              if (stat_i.out_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = stat_i.pos_err ? STAT_RANGE : STAT_FULL;
                state_d           = ST_IDLE;
              end
            end else begin
              cmd_o.shift = SHIFT_INSERT;
              state_d     = ST_IDLE;
            end
          end
          FUNC_DELETE: begin
            if (stat_i.pos_err) begin
              if (stat_i.out_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STAT_RANGE;
                state_d           = ST_IDLE;
              end
            end else begin
              cmd_o.shift = SHIFT_DELETE;
              state_d     = ST_IDLE;
            end
          end
          default: begin
            if (stat_i.empty) begin
              if (stat_i.out_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STAT_EMPTY;
                state_d           = ST_IDLE;
              end
            end else begin
              state_d = ST_DUMP;
            end
          end
        endcase
      end
      ST_DUMP: begin
        // stream the head cell and rotate the list by one per beat
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_elem = 1'b1;
          cmd_o.shift     = SHIFT_ROTATE;
          if (stat_i.dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/pli_dp.sv @@
// Datapath of the positional list unit: shifting cells, length, output register.
module pli_dp #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pli_pkg::pli_cmd_t                 cmd_i,
  output pli_pkg::pli_stat_t                stat_o,
  input  logic [1:0]                        func_i,
  input  logic [pli_pkg::POS_W-1:0]         position_i,
  input  logic signed [pli_pkg::VAL_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pli_pkg::ELEM_W-1:0] element_o,
  output logic                              last_o,
  output logic [1:0]                        status_o
);
  import pli_pkg::*;

  localparam int unsigned LEN_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int unsigned WIDE_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int unsigned OUT_W  = (DATA_WIDTH > ELEM_W) ? DATA_WIDTH : ELEM_W;

  func_e                  func_q;
  logic [POS_W-1:0]       pos_q;
  logic [DATA_WIDTH-1:0]  val_q;
  logic [LEN_W-1:0]       len_q;
  logic [LEN_W-1:0]       idx_q;
  logic [DATA_WIDTH-1:0]  cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0]  prev_w [CAPACITY];
  logic [DATA_WIDTH-1:0]  next_w [CAPACITY];
  logic                   out_valid_q;
  logic [ELEM_W-1:0]      element_q;
  logic                   last_q;
  status_e                status_q;

  logic [WIDE_W-1:0]      val_wide;
  logic [OUT_W-1:0]       head_wide;
  logic [CMP_W-1:0]       pos_c, len_c, tgt_c, lo_c, top_c;
  logic                   out_free;
  logic                   dump_last;

  // sign-extend the input value, then keep DATA_WIDTH bits
  assign val_wide  = WIDE_W'(value_i);
  assign head_wide = OUT_W'(cell_q[0]);

  assign pos_c = CMP_W'(pos_q);
  assign len_c = CMP_W'(len_q);
  assign tgt_c = (func_q == FUNC_APPEND) ? len_c : pos_c;
  assign lo_c  = (cmd_i.shift == SHIFT_DELETE) ? (pos_c - CMP_W'(1)) : '0;
  assign top_c = len_c - CMP_W'(1);

  assign out_free  = !out_valid_q || out_ready_i;
  assign dump_last = (idx_q == (len_q - LEN_W'(1)));

  always_comb begin
    stat_o.func      = func_q;
    stat_o.full      = (len_q == LEN_W'(CAPACITY));
    stat_o.empty     = (len_q == '0);
    stat_o.dump_last = dump_last;
    stat_o.out_free  = out_free;
    case (func_q)
      FUNC_INSERT: stat_o.pos_err = (pos_c > len_c);
      FUNC_DELETE: stat_o.pos_err = (pos_c == '0) || (pos_c > len_c);
      default:     stat_o.pos_err = 1'b0;
    endcase
  end

  // neighbor taps of each cell
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign prev_w[g] = '0;
    end else begin : g_prev
      assign prev_w[g] = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign next_w[g] = '0;
    end else begin : g_next
      assign next_w[g] = cell_q[g+1];
    end
  end

  // hold the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      pos_q  <= position_i;
      val_q  <= val_wide[DATA_WIDTH-1:0];
    end
  end

  // the affected cells shift together: right for insert, left for delete and rotate
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      case (cmd_i.shift) inside
        SHIFT_INSERT: begin
          if (CMP_W'(i) == tgt_c) begin
            cell_q[i] <= val_q;
          end else if ((CMP_W'(i) > tgt_c) && (CMP_W'(i) <= len_c)) begin
            cell_q[i] <= prev_w[i];
          end
        end
        SHIFT_DELETE, SHIFT_ROTATE: begin
          if ((CMP_W'(i) >= lo_c) && (CMP_W'(i) < top_c)) begin
            cell_q[i] <= next_w[i];
          end else if ((cmd_i.shift == SHIFT_ROTATE) && (CMP_W'(i) == top_c)) begin
            cell_q[i] <= cell_q[0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.shift == SHIFT_INSERT) begin
        len_q <= len_q + LEN_W'(1);
      end else if (cmd_i.shift == SHIFT_DELETE) begin
        len_q <= len_q - LEN_W'(1);
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.shift == SHIFT_ROTATE) begin
        idx_q <= idx_q + LEN_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      element_q <= cmd_i.emit_elem ? head_wide[ELEM_W-1:0] : '0;
      last_q    <= cmd_i.emit_elem ? dump_last : 1'b1;
      status_q  <= cmd_i.emit_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = element_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule

@@ sv/positional_list_insert_delete_unit.sv @@
// Positional list unit: ordered list with append, insert, delete and dump.
//
// Usage: one input channel (in_i) carries func, position and value; one
// result channel (out_o) carries element, last and status. Both are
// valid/ready; a beat moves when valid and ready are high at a clock edge.
// Append, insert and delete give no result beat unless they fail; a failed
// operation gives one beat with status range or full, element 0, last 1.
// A dump gives one beat per element in list order, last set on the final
// one, or a single empty-status beat for an empty list.
// Timing: an item is accepted in the idle state and executed in the exec
// state; the affected cells of an append, insert or delete shift together.
// A dump then streams the head cell and rotates the list by one cell per
// beat, which restores the order when the last element leaves. in_i.ready
// is high only between items.
// Receiver stall: the result register holds its beat; an error or dump beat
// waits until it is taken, the list state does not move meanwhile.
// Reset: the list length clears to zero and the output register empties;
// cell contents are not cleared and are only read after being written.
module positional_list_insert_delete_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pli_in_if.sink    in_i,
  pli_out_if.source out_o
);
  import pli_pkg::*;

  pli_cmd_t  cmd;
  pli_stat_t stat;
  logic      in_ready;

  // controller: sequences one item at a time
  pli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: cells, length, dump counter and result register
  pli_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (in_i.func),
    .position_i  (in_i.position),
    .value_i     (in_i.value),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .element_o   (out_o.element),
    .last_o      (out_o.last),
    .status_o    (out_o.status)
  );

  assign in_i.ready = in_ready;

endmodule

@@ sv/pli_checker.sv @@
// Port-level assertions for the positional list unit, bound to the top level.
module pli_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [pli_pkg::ELEM_W-1:0] element_i,
  input logic                       last_i,
  input logic [1:0]                 status_i
);
  import pli_pkg::*;

  // one item at a time: ready drops right after an accepted beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted twice in a row");

  // error and empty beats carry element 0 and close the item
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i != STAT_ELEM)) |-> ((element_i == '0) && last_i))
    else $error("status beat with element or without last");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(element_i) && $stable(last_i) && $stable(status_i)))
    else $error("stalled result beat changed");

  // a new item is not accepted while a dump is mid-stream
  a_dump_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i == STAT_ELEM) && !last_i) |-> !in_ready_i)
    else $error("input ready during a dump");

endmodule

bind positional_list_insert_delete_unit pli_checker u_pli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .element_i   (out_o.element),
  .last_i      (out_o.last),
  .status_i    (out_o.status)
);
